[src/cbrf_pkg.sv]
// shared types, register map and constants of the cubic bisection root finder
package cbrf_pkg;

    localparam int COORD_W  = 24;
    localparam int FVAL_W   = 40;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;
    localparam int TOL_W    = 24;
    localparam int ITER_W   = 7;

    // register map, index = paddr / 4
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_ITER      = 2'd2;

    localparam logic [MODE_W-1:0] MODE_TOL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;

    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 24'd66;
    localparam logic [ITER_W-1:0] ITER_RESET = 7'd20;

    localparam logic [STATUS_W-1:0] ST_STEP    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ROOT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADINT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADMODE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CAP     = 3'd4;

    // f(x) = x^3 - 4x - 9
    localparam int CUBIC_LIN_SHIFT = 2;
    localparam int CUBIC_CONST     = 9;

    typedef struct packed {
        logic                load_in;
        logic                load_b;
        logic                load_fa;
        logic                load_mid;
        logic                update;
        logic                emit;
        logic                emit_clear;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_last;
    } cbrf_cmd_t;

    typedef struct packed {
        logic same_sign;
        logic f_zero;
        logic tol_met;
        logic out_free;
    } cbrf_sts_t;

endpackage

[src/cbrf_cfg.sv]
// apb register file: mode, tolerance and iteration limit
module cbrf_cfg
    import cbrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [MODE_W-1:0] mode,
    output logic [TOL_W-1:0]  tolerance,
    output logic [ITER_W-1:0] iteration_limit
);

    logic [MODE_W-1:0] mode_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            tol_reg  <= TOL_RESET;
            iter_reg <= ITER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:      mode_reg <= pwdata[MODE_W-1:0];
                REG_TOLERANCE: tol_reg  <= pwdata[TOL_W-1:0];
                REG_ITER:      iter_reg <= pwdata[ITER_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:      prdata = 32'(mode_reg);
            REG_TOLERANCE: prdata = 32'(tol_reg);
            REG_ITER:      prdata = 32'(iter_reg);
            default:       prdata = 32'd0;
        endcase
    end

    assign mode            = mode_reg;
    assign tolerance       = tol_reg;
    assign iteration_limit = iter_reg;

endmodule

[src/cbrf_dp.sv]
// datapath: interval registers, two-stage cubic evaluator, output register
module cbrf_dp
    import cbrf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [COORD_W-1:0]  interval_low,
    input  logic signed [COORD_W-1:0]  interval_high,
    input  logic [TOL_W-1:0]           tolerance,
    input  cbrf_cmd_t                  cmd,
    output cbrf_sts_t                  sts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_W-1:0]  midpoint,
    output logic signed [FVAL_W-1:0]   f_value,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    localparam int PROD_W = 2 * COORD_W;
    localparam int SQ_W   = PROD_W - FRAC_BITS;
    localparam int CU_W   = SQ_W + COORD_W - FRAC_BITS;
    localparam int FX_W   = ((CU_W > 30) ? CU_W : 30) + 2;
    localparam logic [FX_W-1:0] CONST_FX = FX_W'(CUBIC_CONST) << FRAC_BITS;

    logic signed [COORD_W-1:0] a_reg, b_reg;
    logic                      fa_neg_reg, fa_pos_reg;

    // evaluator pipeline, runs every cycle; holding x holds the result
    logic signed [COORD_W-1:0]        x_reg, xd_reg, xdd_reg;
    logic signed [SQ_W-1:0]           sq_reg;
    logic signed [CU_W-1:0]           cu_reg;
    logic signed [PROD_W-1:0]         sq_prod;
    logic signed [SQ_W+COORD_W-1:0]   cu_prod;
    logic signed [FX_W-1:0]           f_val;

    logic signed [COORD_W:0]   sum;
    logic signed [COORD_W-1:0] mid_val;
    logic signed [COORD_W-1:0] an, bn;
    logic signed [COORD_W:0]   diff;
    logic [COORD_W:0]          width;
    logic                      f_neg, f_pos, opposite;

    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  mid_out_reg;
    logic signed [FVAL_W-1:0]   f_out_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic                       last_reg;

    assign sq_prod = x_reg * x_reg;
    assign cu_prod = sq_reg * xd_reg;

    always_ff @(posedge clk)
    begin
        sq_reg  <= SQ_W'(sq_prod >>> FRAC_BITS);
        xd_reg  <= x_reg;
        cu_reg  <= CU_W'(cu_prod >>> FRAC_BITS);
        xdd_reg <= xd_reg;
    end

    assign f_val = FX_W'(cu_reg) - (FX_W'(xdd_reg) <<< CUBIC_LIN_SHIFT) - CONST_FX;
    assign f_neg = f_val[FX_W-1];
    assign f_pos = !f_val[FX_W-1] && (f_val != '0);

    assign sum     = (COORD_W+1)'(a_reg) + (COORD_W+1)'(b_reg);
    assign mid_val = COORD_W'(sum >>> 1);

    // xdd holds the midpoint while a step is decided
    assign opposite = (fa_neg_reg && f_pos) || (fa_pos_reg && f_neg);
    assign an       = opposite ? a_reg : xdd_reg;
    assign bn       = opposite ? xdd_reg : b_reg;
    assign diff     = (COORD_W+1)'(bn) - (COORD_W+1)'(an);
    assign width    = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);

    assign sts.same_sign = (fa_pos_reg && f_pos) || (fa_neg_reg && f_neg);
    assign sts.f_zero    = (f_val == '0);
    assign sts.tol_met   = width < (COORD_W+1)'(tolerance);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= interval_low;
            b_reg <= interval_high;
            x_reg <= interval_low;
        end
        else if (cmd.load_b)
        begin
            x_reg <= b_reg;
        end
        else if (cmd.load_mid)
        begin
            x_reg <= mid_val;
        end

        if (cmd.load_fa)
        begin
            fa_neg_reg <= f_neg;
            fa_pos_reg <= f_pos;
        end
        else if (cmd.update)
        begin
            if (opposite)
            begin
                b_reg <= xdd_reg;
            end
            else
            begin
                a_reg      <= xdd_reg;
                fa_neg_reg <= f_neg;
                fa_pos_reg <= f_pos;
            end
        end

        if (cmd.emit)
        begin
            mid_out_reg <= cmd.emit_clear ? '0 : xdd_reg;
            f_out_reg   <= cmd.emit_clear ? '0 : FVAL_W'(f_val);
            status_reg  <= cmd.emit_status;
            last_reg    <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign midpoint  = mid_out_reg;
    assign f_value   = f_out_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("output word appeared without an emit command");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($past(cmd.emit) == 1'b0))
        else $error("stalled output word was overwritten");

endmodule

[src/cbrf_ctrl.sv]
// controller: sequences end evaluation, bisection steps and result emission
module cbrf_ctrl
    import cbrf_pkg::*;
#(
    parameter int MAX_STEPS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [ITER_W-1:0] iteration_limit,
    input  cbrf_sts_t         sts,
    output cbrf_cmd_t         cmd
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int CMP_W  = (STEP_W > ITER_W) ? STEP_W : ITER_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOADB = 4'd1;
    localparam logic [3:0] S_FILL  = 4'd2;
    localparam logic [3:0] S_FA    = 4'd3;
    localparam logic [3:0] S_FB    = 4'd4;
    localparam logic [3:0] S_MID   = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_CU    = 4'd7;
    localparam logic [3:0] S_DEC   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] step_num;
    logic              count_done, cap_hit, rule_met;

    assign step_num   = step_reg + 1'b1;
    assign count_done = CMP_W'(step_num) >= CMP_W'(iteration_limit);
    assign cap_hit    = CMP_W'(step_num) >= CMP_W'(MAX_STEPS);
    assign rule_met   = (mode == MODE_TOL) ? sts.tol_met : count_done;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_LOADB;
                end
            end
            S_LOADB:
            begin
                cmd.load_b = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                state_next = S_FA;
            end
            S_FA:
            begin
                cmd.load_fa = 1'b1;
                state_next  = S_FB;
            end
            S_FB:
            begin
                if (sts.same_sign || !(mode inside {MODE_TOL, MODE_COUNT}))
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_clear  = 1'b1;
                        cmd.emit_status = sts.same_sign ? ST_BADINT : ST_BADMODE;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (mode == MODE_COUNT && iteration_limit == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                cmd.load_mid = 1'b1;
                state_next   = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_CU;
            end
            S_CU:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.update = 1'b1;
                    step_next  = step_num;
                    if (sts.f_zero)
                    begin
                        cmd.emit_status = ST_ROOT;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (rule_met)
                    begin
                        cmd.emit_status = ST_STEP;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (cap_hit)
                    begin
                        cmd.emit_status = ST_CAP;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_status = ST_STEP;
                        state_next      = S_MID;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(step_reg) <= CMP_W'(MAX_STEPS))
        else $error("step counter ran past the cap");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit while output register is occupied");

    a_root_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_status == ST_ROOT) |-> sts.f_zero)
        else $error("root reported on nonzero f");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_last) |=> in_ready)
        else $error("run continued after its final word");

endmodule

[src/cubic_bisection_root_finder.sv]
// top level: bisection root finder for f(x) = x^3 - 4x - 9 on signed Q8.16 intervals
//
// input stream: one word per interval, tdata = {interval_high, interval_low}.
// output stream: one word per bisection step, tdata = {f_value, midpoint},
// tuser = status, tlast marks the final word of an interval's run.
// a run with same-sign ends or an unknown mode gives a single word with zero data.
// count mode with an iteration limit of zero gives no word at all, unless the ends have the same sign.
// the apb port holds mode, tolerance and iteration limit; write them only while idle.
// sequencing: both ends are evaluated first, then each step runs through the states
// midpoint, square, cube and decide in the shared two-multiplier evaluator, and
// each step's word is held in the output register.
// s_axis_tready is high only while no run is in progress; the last word of a
// run may still wait in the output register while the next interval is taken.
// a stalled receiver freezes the current step until the previous word is taken.
// reset empties the output register, returns to idle and loads register defaults
// (mode 0, tolerance 66, iteration limit 20).
module cubic_bisection_root_finder
    import cbrf_pkg::*;
#(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // interval_low, interval_high
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // midpoint, f_value
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [MODE_W-1:0]         mode;
    logic [TOL_W-1:0]          tolerance;
    logic [ITER_W-1:0]         iteration_limit;
    cbrf_cmd_t                 cmd;
    cbrf_sts_t                 sts;
    logic signed [COORD_W-1:0] midpoint;
    logic signed [FVAL_W-1:0]  f_value;

    cbrf_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mode            (mode),
        .tolerance       (tolerance),
        .iteration_limit (iteration_limit)
    );

    cbrf_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .mode            (mode),
        .iteration_limit (iteration_limit),
        .sts             (sts),
        .cmd             (cmd)
    );

    cbrf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .interval_low  (s_axis_tdata[23:0]),
        .interval_high (s_axis_tdata[47:24]),
        .tolerance     (tolerance),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .midpoint      (midpoint),
        .f_value       (f_value),
        .status        (m_axis_tuser),
        .last          (m_axis_tlast)
    );

    assign m_axis_tdata = {f_value, midpoint};

endmodule

[dv/cbrf_step_checker.sv]
// checker for the cubic bisection root finder: predicts every result word and compares it
module cbrf_step_checker
    import cbrf_pkg::*;
#(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // interval_low, interval_high
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // midpoint, f_value
    input  logic [2:0]  m_axis_tuser,   // status
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          words_pending,
    output int          words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0]  midpoint;
        logic [FVAL_W-1:0]   f_value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } step_word_t;

    step_word_t          predicted_words[$];
    logic [MODE_W-1:0]   cfg_mode;
    logic [TOL_W-1:0]    cfg_tol;
    logic [ITER_W-1:0]   cfg_iter;
    int                  err_count;
    int                  checked_count;

    // x^3 - 4x - 9 in raw fixed point, each product floored back to FRAC_BITS
    function automatic longint cubic_at(input longint x);
        longint sq;
        longint cu;
        sq = (x * x) >>> FRAC_BITS;
        cu = (sq * x) >>> FRAC_BITS;
        return cu - (x <<< CUBIC_LIN_SHIFT) - (longint'(CUBIC_CONST) <<< FRAC_BITS);
    endfunction

    function automatic void queue_word(input longint mid, input longint fv,
                                       input logic [STATUS_W-1:0] st, input logic lst);
        step_word_t w;
        w.midpoint = mid[COORD_W-1:0];
        w.f_value  = fv[FVAL_W-1:0];
        w.status   = st;
        w.last     = lst;
        predicted_words.push_back(w);
    endfunction

    task automatic bisect_interval(input logic [47:0] word);
        longint a;
        longint b;
        longint fa;
        longint fb;
        longint m;
        longint fm;
        longint width;
        logic   done;
        a  = longint'($signed(word[23:0]));
        b  = longint'($signed(word[47:24]));
        fa = cubic_at(a);
        fb = cubic_at(b);
        if ((fa > 0 && fb > 0) || (fa < 0 && fb < 0)) begin
            queue_word(0, 0, ST_BADINT, 1'b1);
            return;
        end
        if (cfg_mode != MODE_TOL && cfg_mode != MODE_COUNT) begin
            queue_word(0, 0, ST_BADMODE, 1'b1);
            return;
        end
        if (cfg_mode == MODE_COUNT && cfg_iter == 0)
            return;
        for (int steps = 1; steps <= MAX_STEPS; steps++) begin
            m  = (a + b) >>> 1;
            fm = cubic_at(m);
            if (fm == 0) begin
                queue_word(m, fm, ST_ROOT, 1'b1);
                return;
            end
            // keep the half where the sign still changes
            if ((fa < 0 && fm > 0) || (fa > 0 && fm < 0)) begin
                b = m;
            end
            else begin
                a  = m;
                fa = fm;
            end
            if (cfg_mode == MODE_TOL) begin
                width = (b >= a) ? (b - a) : (a - b);
                done  = width < longint'(cfg_tol);
            end
            else begin
                done = steps >= int'(cfg_iter);
            end
            if (done) begin
                queue_word(m, fm, ST_STEP, 1'b1);
                return;
            end
            if (steps == MAX_STEPS)
                queue_word(m, fm, ST_CAP, 1'b1);
            else
                queue_word(m, fm, ST_STEP, 1'b0);
        end
    endtask

    function automatic void note_mismatch(input string what);
        err_count++;
        if (err_count <= 10)
            $display("%t mismatch: %s", $realtime, what);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        step_word_t got;
        step_word_t want;
        if (!rst_n) begin
            cfg_mode  = MODE_RESET;
            cfg_tol   = TOL_RESET;
            cfg_iter  = ITER_RESET;
            predicted_words.delete();
            words_pending <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MODE:      cfg_mode = pwdata[MODE_W-1:0];
                    REG_TOLERANCE: cfg_tol  = pwdata[TOL_W-1:0];
                    REG_ITER:      cfg_iter = pwdata[ITER_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                bisect_interval(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.midpoint = m_axis_tdata[COORD_W-1:0];
                got.f_value  = m_axis_tdata[COORD_W+FVAL_W-1:COORD_W];
                got.status   = m_axis_tuser;
                got.last     = m_axis_tlast;
                checked_count++;
                if (predicted_words.size() == 0) begin
                    note_mismatch($sformatf("unexpected word mid %h f %h status %0d last %0b",
                        got.midpoint, got.f_value, got.status, got.last));
                end
                else begin
                    want = predicted_words.pop_front();
                    if (got !== want)
                        note_mismatch($sformatf(
                            "exp mid %h f %h status %0d last %0b, got mid %h f %h status %0d last %0b",
                            want.midpoint, want.f_value, want.status, want.last,
                            got.midpoint, got.f_value, got.status, got.last));
                end
            end
            words_pending <= predicted_words.size();
        end
        mismatches    <= err_count;
        words_checked <= checked_count;
    end

endmodule

[dv/testbench.sv]
// testbench top for the cubic bisection root finder: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cbrf_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int ROOT_Q      = 177375;   // real root near 2.7065 in Q8.16
    localparam logic [MODE_W-1:0] MODE_UNDEF_2 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNDEF_3 = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // interval_low, interval_high
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // midpoint, f_value
    logic [2:0]  m_axis_tuser;          // status
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int words_pending;
    int words_checked;
    int intervals_sent = 0;
    int settings_used = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cubic_bisection_root_finder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cbrf_step_checker step_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    // offer one interval and hold it until taken, then maybe idle a burst
    task automatic put_interval(input int lo, input int hi);
        s_axis_tdata  <= {hi[23:0], lo[23:0]};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        intervals_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_drained(input int pad);
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (pad) @(posedge clk);
    endtask

    // registers change only with the block idle
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        wait_drained(24);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver: ready and stall segments, plus the one long hold
    initial begin
        int seg;
        @(posedge clk);
        forever begin
            if (hold_cycles > 0) begin
                seg = hold_cycles;
                hold_cycles = 0;
                m_axis_tready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 2) == 0) begin
                seg = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
            end
            else begin
                seg = $urandom_range(1, 16);
                m_axis_tready <= 1'b1;
            end
            repeat (seg) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int                lo;
        int                hi;
        int                t;
        int                kind;
        logic [MODE_W-1:0] md;
        logic [TOL_W-1:0]  tol;
        logic [ITER_W-1:0] iters;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: tolerance mode, tolerance 66
        put_interval(2 <<< 16, 3 <<< 16);
        put_interval(3 <<< 16, 2 <<< 16);               // reversed ends
        put_interval(-8388608, 8388607);
        put_interval(8388607, -8388608);
        put_interval(-1, 8388607);
        put_interval(0, 8388607);
        put_interval(-8388608, 0);                       // both ends negative
        put_interval(8388607, 4 <<< 16);                 // both ends positive
        put_interval(0, 0);

        // tolerance zero never stops, so the step cap ends the run
        set_reg(REG_TOLERANCE, 32'd0);
        put_interval(2 <<< 16, 3 <<< 16);
        // widest tolerance with junk above the field: one step
        set_reg(REG_TOLERANCE, 32'hA5FF_FFFF);
        put_interval(-8388608, 8388607);
        settings_used += 3;

        // count mode, written with junk in the upper bits
        set_reg(REG_MODE, {30'h3FFF_FFFF, MODE_COUNT});
        set_reg(REG_ITER, 32'd1);
        put_interval(2 <<< 16, 3 <<< 16);
        set_reg(REG_ITER, 32'd64);
        put_interval(-8388608, 8388607);                 // stops exactly at the cap
        set_reg(REG_ITER, 32'hFFFF_FFFF);                // 127, above the cap
        put_interval(2 <<< 16, 3 <<< 16);
        set_reg(REG_ITER, 32'd0);
        put_interval(2 <<< 16, 3 <<< 16);                // no word at all
        put_interval(0, 0);
        set_reg(REG_MODE, {30'd0, MODE_UNDEF_2});
        put_interval(2 <<< 16, 3 <<< 16);
        put_interval(8388607, 4 <<< 16);
        set_reg(REG_MODE, {30'd0, MODE_UNDEF_3});
        put_interval(3 <<< 16, 2 <<< 16);
        settings_used += 6;

        for (int phase = 0; phase < 7; phase++) begin
            t = $urandom_range(0, 9);
            if (phase == 6)
                md = (t < 5) ? MODE_TOL : MODE_COUNT;
            else if (t < 4)
                md = MODE_TOL;
            else if (t < 8)
                md = MODE_COUNT;
            else
                md = (t == 8) ? MODE_UNDEF_2 : MODE_UNDEF_3;
            t = $urandom_range(0, 9);
            if (t < 2)
                tol = TOL_W'($urandom_range(0, 3));
            else if (t < 7)
                tol = TOL_W'($urandom_range(4, 4096));
            else
                tol = TOL_W'($urandom_range(4097, 24'hFFFFFF));
            t = $urandom_range(0, 9);
            if (t == 0)
                iters = '0;
            else if (t < 8)
                iters = ITER_W'($urandom_range(1, 64));
            else
                iters = ITER_W'($urandom_range(65, 127));
            if (phase == 6 && iters == 0)
                iters = 7'd12;
            set_reg(REG_MODE, ($urandom() << MODE_W) | md);
            set_reg(REG_TOLERANCE, ($urandom() << TOL_W) | tol);
            set_reg(REG_ITER, ($urandom() << ITER_W) | iters);
            settings_used++;
            if (phase == 6) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            // back up the output so the input side has to wait
            if (phase == 1)
                hold_cycles = 300;
            for (int k = 0; k < 27; k++) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    lo = int'($urandom_range(0, 8388608 + ROOT_Q - 400)) - 8388608;
                    hi = ROOT_Q + 600 + int'($urandom_range(0, 8388607 - ROOT_Q - 600));
                end
                else if (kind < 7) begin
                    lo = ROOT_Q - int'($urandom_range(0, 3000));
                    hi = ROOT_Q + int'($urandom_range(0, 3000));
                end
                else begin
                    lo = $urandom();
                    hi = $urandom();
                end
                if (kind < 7 && $urandom_range(0, 1) == 1)
                    put_interval(hi, lo);
                else
                    put_interval(lo, hi);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained(300);
        $display("summary: %0d intervals under %0d register settings, %0d result words checked",
                 intervals_sent, settings_used, words_checked);
        $display("summary: ends, reversed ends, both sign failures, bad modes, cap and long stall");
        if (mismatches == 0 && words_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
src/cbrf_pkg.sv
src/cbrf_cfg.sv
src/cbrf_dp.sv
src/cbrf_ctrl.sv
src/cubic_bisection_root_finder.sv
dv/cbrf_step_checker.sv
dv/testbench.sv
